// ----- rtl/mse_pkg.sv -----
package mse_pkg;

  // Operation codes of the decoded instruction; 14 and 15 have no meaning.
  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_ADDI = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_MFLO = 4'd4,
    CMD_MFHI = 4'd5,
    CMD_LW   = 4'd6,
    CMD_SW   = 4'd7,
    CMD_LA   = 4'd8,
    CMD_J    = 4'd9,
    CMD_BEQ  = 4'd10,
    CMD_BGT  = 4'd11,
    CMD_BLT  = 4'd12,
    CMD_NOP  = 4'd13
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_ITER,
    ST_ADDR,
    ST_WRAP,
    ST_MEMACC,
    ST_MEMRD,
    ST_FINISH
  } state_e;

  localparam int unsigned WORD_W = 32;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage

// ----- rtl/mse_muldiv.sv -----
module mse_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mse_pkg::md_req_t req_i,
  input  logic [31:0]      op_a_i,
  input  logic [31:0]      op_b_i,
  output logic             done_o,
  output logic [31:0]      lo_o,
  output logic [31:0]      rem_o
);
  import mse_pkg::*;

  // One bit per cycle. Multiply: a_q accumulates, b_q is the shifted
  // multiplicand, c_q the multiplier. Divide: a_q is the partial remainder,
  // b_q the divisor, c_q the dividend that turns into the quotient.
  logic [32:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] c_q, c_d;
  logic [4:0]  cnt_q;
  logic        run_q;
  logic        done_q;
  logic        div_q;

  logic [32:0] add_x, add_y;
  logic        add_cin;
  logic [33:0] add_sum;
  logic [32:0] shifted;

  assign shifted = {a_q[31:0], c_q[WORD_W-1]};

  always_comb begin
    if (div_q) begin
      add_x   = shifted;
      add_y   = ~{1'b0, b_q};
      add_cin = 1'b1;
    end else begin
      add_x   = a_q;
      add_y   = c_q[0] ? {1'b0, b_q} : 33'd0;
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {33'd0, add_cin};

    if (div_q) begin
      // A carry out means the shifted remainder was not below the divisor.
      a_d = add_sum[33] ? add_sum[32:0] : shifted;
      b_d = b_q;
      c_d = {c_q[30:0], add_sum[33]};
    end else begin
      a_d = {1'b0, add_sum[31:0]};
      b_d = {b_q[30:0], 1'b0};
      c_d = {1'b0, c_q[31:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= '0;
      b_q   <= op_b_i;
      c_q   <= op_a_i;
      div_q <= req_i.is_div;
    end else if (run_q) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  assign done_o = done_q;
  assign lo_o   = div_q ? c_q : a_q[31:0];
  assign rem_o  = a_q[31:0];

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("muldiv started while running");

  a_done_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(run_q) && !run_q))
    else $error("muldiv done without a finished run");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && div_q && (b_q != 32'd0)) |-> (a_q < {1'b0, b_q}))
    else $error("muldiv remainder not below divisor");

endmodule

// ----- rtl/mips_subset_execute_core.sv -----
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      cmd_i, dest_reg_i, first_src_reg_i,
//                                                     second_src_reg_i, immediate_i
// result    out        done_o high for one cycle      write_enable_o, write_reg_o,
//                                                     write_value_o, branch_taken_o,
//                                                     div_by_zero_o, mem_address_o
//
// A word is accepted at a rising edge with start high and busy low; exactly one
// result word follows. mul and div with a nonzero divisor keep busy high through
// read, decode, the shared unit's run (32 one-bit steps and its done strobe) and
// a finishing step. sw and lw take longer: the word address is wrapped to the
// memory depth by a reciprocal multiply and a correcting subtract, in the address
// and wrap states, before the memory is accessed, and lw adds a read state; all
// else passes through read, decode and finish only. done_o is high in the first
// cycle after busy falls, and a new word may be taken at the edge that ends it.
// Reset clears the register file (through per-entry valid bits), hi and lo; the
// data memory holds nothing defined until written. The receiver cannot stall.
module mips_subset_execute_core #(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned REG_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [4:0]  first_src_reg_i,
  input  logic [4:0]  second_src_reg_i,
  input  logic signed [31:0] immediate_i,
  output logic        done_o,
  output logic        write_enable_o,
  output logic [4:0]  write_reg_o,
  output logic signed [31:0] write_value_o,
  output logic        branch_taken_o,
  output logic        div_by_zero_o,
  output logic [9:0]  mem_address_o
);
  import mse_pkg::*;

  localparam int unsigned RW = $clog2(REG_COUNT);
  localparam int unsigned AW = $clog2(MEM_WORDS);

  // The floor of 2^RECIP_SHIFT / MEM_WORDS. With it the quotient estimate of a
  // 32-bit sum is at most one below the true quotient, so one subtraction of the
  // depth finishes the wrap.
  localparam int unsigned RECIP_SHIFT = 32 + AW;
  localparam logic [32:0] MOD_RECIP = 33'((64'd1 << RECIP_SHIFT) / 64'(MEM_WORDS));

  // Register indices wrap modulo REG_COUNT; at most four subtractions on a
  // five-bit value cover the smallest legal register count.
  function automatic logic [RW-1:0] reg_idx(input logic [4:0] v);
    logic [5:0] t;
    t = {1'b0, v};
    for (int k = 0; k < 4; k++) begin
      if (t >= 6'(REG_COUNT)) begin
        t = t - 6'(REG_COUNT);
      end
    end
    return t[RW-1:0];
  endfunction

  state_e state_q, state_d;

  // Latched command.
  logic [3:0]    cmd_q;
  logic [RW-1:0] dst_q;
  logic [31:0]   imm_q;
  logic [31:0]   op_t_q, op_s_q, op_d_q;

  // Architectural state besides the memories.
  logic [31:0] hi_q, lo_q;

  // Result being assembled.
  logic        res_wen_q;
  logic [31:0] res_val_q;
  logic        res_taken_q;
  logic        res_dz_q;
  logic [9:0]  res_addr_q;

  // Register file: two read ports with registered data, one write port.
  logic [31:0]   rf_mem [REG_COUNT];
  logic          rf_valid_q [REG_COUNT];
  logic [RW-1:0] rf_ra, rf_rb;
  logic [31:0]   rf_da_q, rf_db_q;
  logic          rf_za_q, rf_zb_q;
  logic [31:0]   rd_a, rd_b;
  logic          rf_we;

  // Data memory.
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] dm_rd_q;
  logic        dm_we;

  // Address wrap to the memory depth.
  logic [31:0]   addr_sum_q;
  logic [31:0]   addr_quo_q;
  logic [AW-1:0] addr_q;
  logic [64:0]   recip_prod;
  logic [31:0]   wrap_rem, wrap_addr;

  // Shared multiply/divide unit.
  md_req_t     md_req;
  logic [31:0] md_a, md_b;
  logic        md_done;
  logic [31:0] md_lo, md_rem;

  logic [31:0] alu_a, alu_b, alu_sum;
  logic [31:0] abs_t, abs_s;
  logic        neg_t, neg_s;
  logic [31:0] quot_fix, rem_fix;
  logic        done_q;

  assign busy = (state_q != ST_IDLE);

  // Port A reads rt while idle and the store/compare register next; port B rs.
  assign rf_ra = (state_q == ST_READ) ? dst_q : reg_idx(first_src_reg_i);
  assign rf_rb = reg_idx(second_src_reg_i);

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[dst_q] <= res_val_q;
    end
    rf_da_q <= rf_mem[rf_ra];
    rf_db_q <= rf_mem[rf_rb];
  end

  // Register zero and entries not written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_za_q <= 1'b1;
      rf_zb_q <= 1'b1;
      for (int i = 0; i < int'(REG_COUNT); i++) begin
        rf_valid_q[i] <= 1'b0;
      end
    end else begin
      rf_za_q <= (rf_ra == '0) || !rf_valid_q[rf_ra];
      rf_zb_q <= (rf_rb == '0) || !rf_valid_q[rf_rb];
      if (rf_we) begin
        rf_valid_q[dst_q] <= 1'b1;
      end
    end
  end

  assign rd_a = rf_za_q ? 32'd0 : rf_da_q;
  assign rd_b = rf_zb_q ? 32'd0 : rf_db_q;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[addr_q] <= op_d_q;
    end
    dm_rd_q <= dmem[addr_q];
  end

  // One adder serves add, addi and the lw/sw base plus offset.
  always_comb begin
    alu_a   = ((cmd_q == CMD_ADD) || (cmd_q == CMD_ADDI)) ? op_t_q : op_s_q;
    alu_b   = (cmd_q == CMD_ADD) ? op_s_q : imm_q;
    alu_sum = alu_a + alu_b;
  end

  // The quotient estimate is registered; the remainder left over is below twice
  // the depth and needs at most one more subtraction.
  assign recip_prod = {33'd0, addr_sum_q} * {32'd0, MOD_RECIP};
  assign wrap_rem   = addr_sum_q - (addr_quo_q * 32'(MEM_WORDS));
  assign wrap_addr  = (wrap_rem >= 32'(MEM_WORDS)) ? (wrap_rem - 32'(MEM_WORDS)) : wrap_rem;

  assign neg_t = op_t_q[31];
  assign neg_s = op_s_q[31];
  assign abs_t = neg_t ? (~op_t_q + 32'd1) : op_t_q;
  assign abs_s = neg_s ? (~op_s_q + 32'd1) : op_s_q;

  // The quotient is negative when signs differ; the remainder follows the dividend.
  assign quot_fix = (neg_t != neg_s) ? (~md_lo + 32'd1) : md_lo;
  assign rem_fix  = neg_t ? (~md_rem + 32'd1) : md_rem;

  always_comb begin
    state_d = state_q;
    md_req  = '0;
    md_a    = op_s_q;
    md_b    = op_t_q;
    dm_we   = 1'b0;
    rf_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cmd_q)
          CMD_MUL: begin
            md_req.start = 1'b1;
          end
          CMD_DIV: begin
            md_req.start  = (op_s_q != 32'd0);
            md_req.is_div = 1'b1;
            md_a          = abs_t;
            md_b          = abs_s;
          end
          default: begin
          end
        endcase
        if ((cmd_q == CMD_LW) || (cmd_q == CMD_SW)) begin
          state_d = ST_ADDR;
        end else begin
          state_d = md_req.start ? ST_ITER : ST_FINISH;
        end
      end
      ST_ITER: begin
        if (md_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_ADDR: begin
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        state_d = ST_MEMACC;
      end
      ST_MEMACC: begin
        dm_we   = (cmd_q == CMD_SW);
        state_d = (cmd_q == CMD_LW) ? ST_MEMRD : ST_FINISH;
      end
      ST_MEMRD: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        rf_we   = res_wen_q && (dst_q != '0);
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      hi_q    <= '0;
      lo_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FINISH);
      if ((state_q == ST_ITER) && md_done && (cmd_q == CMD_DIV)) begin
        lo_q <= quot_fix;
        hi_q <= rem_fix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_q <= cmd_i;
          dst_q <= reg_idx(dest_reg_i);
          imm_q <= immediate_i;
        end
      end
      ST_READ: begin
        op_t_q <= rd_a;
        op_s_q <= rd_b;
      end
      ST_DECODE: begin
        op_d_q      <= rd_a;
        addr_sum_q  <= alu_sum;
        res_wen_q   <= 1'b0;
        res_val_q   <= '0;
        res_taken_q <= 1'b0;
        res_dz_q    <= 1'b0;
        res_addr_q  <= '0;
        unique case (cmd_q)
          CMD_ADD, CMD_ADDI: begin
            res_wen_q <= 1'b1;
            res_val_q <= alu_sum;
          end
          CMD_DIV: begin
            res_dz_q <= (op_s_q == 32'd0);
          end
          CMD_MFLO: begin
            res_wen_q <= 1'b1;
            res_val_q <= lo_q;
          end
          CMD_MFHI: begin
            res_wen_q <= 1'b1;
            res_val_q <= hi_q;
          end
          CMD_LW: begin
            res_wen_q <= 1'b1;
          end
          CMD_J: begin
            res_taken_q <= 1'b1;
          end
          CMD_BEQ: begin
            res_taken_q <= (rd_a == op_t_q);
          end
          CMD_BGT: begin
            res_taken_q <= ($signed(rd_a) > $signed(op_t_q));
          end
          CMD_BLT: begin
            res_taken_q <= ($signed(rd_a) < $signed(op_t_q));
          end
          default: begin
          end
        endcase
      end
      ST_ITER: begin
        if (md_done) begin
          unique case (cmd_q)
            CMD_MUL: begin
              res_wen_q <= 1'b1;
              res_val_q <= md_lo;
            end
            CMD_DIV: begin
              res_wen_q <= 1'b1;
              res_val_q <= quot_fix;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADDR: begin
        addr_quo_q <= 32'(recip_prod >> RECIP_SHIFT);
      end
      ST_WRAP: begin
        addr_q     <= wrap_addr[AW-1:0];
        res_addr_q <= wrap_addr[9:0];
        if (cmd_q == CMD_SW) begin
          res_val_q <= op_d_q;
        end
      end
      ST_MEMRD: begin
        res_val_q <= dm_rd_q;
      end
      ST_FINISH: begin
        write_enable_o <= rf_we;
        write_reg_o    <= rf_we ? 5'(dst_q) : 5'd0;
        write_value_o  <= (rf_we || (cmd_q == CMD_SW)) ? res_val_q : 32'd0;
        branch_taken_o <= res_taken_q;
        div_by_zero_o  <= res_dz_q;
        mem_address_o  <= res_addr_q;
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;

  mse_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .op_a_i (md_a),
    .op_b_i (md_b),
    .done_o (md_done),
    .lo_o   (md_lo),
    .rem_o  (md_rem)
  );

  a_done_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without a finishing step");

  a_dz_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_by_zero_o) |-> !write_enable_o)
    else $error("write reported on division by zero");

  a_no_zero_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_enable_o) |-> (write_reg_o != 5'd0))
    else $error("write reported to register zero");

  a_md_done_in_iter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == ST_ITER))
    else $error("shared unit finished outside its wait state");

endmodule
